/* src/psm_pkg.sv */
// psm_pkg: shared types, codes and constants of the pose settle monitor.
// No dependencies; imported by the interfaces and by pose_settle_monitor_unit.
package psm_pkg;

    localparam int ANGLE_W   = 16;
    localparam int IDX_W     = 5;
    localparam int MS_W      = 16;
    localparam int TOL_W     = 15;
    localparam int ITV_W     = 8;
    localparam int SETTLE_W  = 17;
    localparam int CNT_W     = 6;
    localparam int REG_IDX_W = 3;
    localparam int CFG_W     = 16;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_START  = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_SAMPLE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_RUNNING   = 3'd1,
        PH_SETTLING  = 3'd2,
        PH_SUCCEEDED = 3'd3,
        PH_FAILED    = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_BUSY     = 3'd1,
        ERR_DURATION = 3'd2,
        ERR_TIMEOUT  = 3'd3,
        ERR_READ     = 3'd4
    } t_err;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SETTLE    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INTERVAL  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DUR   = 3'd4;

    // configuration reset values
    localparam logic [TOL_W-1:0] RST_TOLERANCE = 15'd32;
    localparam logic [MS_W-1:0]  RST_TIMEOUT   = 16'd1000;
    localparam logic [MS_W-1:0]  RST_SETTLE    = 16'd100;
    localparam logic [ITV_W-1:0] RST_INTERVAL  = 8'd20;
    localparam logic [MS_W-1:0]  RST_MAX_DUR   = 16'd65535;

    typedef struct packed {
        t_cmd                      command;
        logic [IDX_W-1:0]          motor_index;
        logic signed [ANGLE_W-1:0] angle;
        logic [MS_W-1:0]           dur_ms;
        logic                      read_failed;
        logic                      last_sample;
    } t_in_item;

    typedef struct packed {
        t_phase status;
        t_err   error;
        logic   accepted;
        logic   read_request;
    } t_out_item;

    typedef struct packed {
        logic [REG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     value;
    } t_cfg_write;

endpackage

/* src/psm_ifs.sv */
// psm_ifs: valid/ready channel interfaces for requests, results and config writes.
// Depends on psm_pkg for the payload structs.
interface psm_in_if import psm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface psm_out_if import psm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface psm_cfg_if import psm_pkg::*; ();
    logic       valid;
    logic       ready;
    t_cfg_write data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/pose_settle_monitor_unit.sv */
// pose_settle_monitor_unit: top level of the pose settle monitor.
// Depends on psm_pkg, the channel interfaces in psm_ifs and psm_ram.
//
//  channel   dir   modport       payload        purpose
//  i_in      in    psm_in_if     t_in_item      load / start / tick / sample requests
//  o_out     out   psm_out_if    t_out_item     one result per request
//  i_cfg     in    psm_cfg_if    t_cfg_write    register writes, always ready
//
// One request a cycle, sustained while the output is not stalled. A request enters
// the stage-1 register while its target angle is read from the RAM; from there
// it is evaluated against the state registers and its result lands in the output
// register. A load in stage 1 and a sample entering behind it on the same motor
// are resolved by forwarding the written angle. A stalled output holds stage 1
// and, once stage 1 is full, the input. Reset is synchronous and takes effect at
// once: no clearing pass, target angles are undefined until loaded.
module pose_settle_monitor_unit import psm_pkg::*; #(
    parameter int MOTOR_COUNT = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psm_in_if.sink     i_in,
    psm_out_if.source  o_out,
    psm_cfg_if.sink    i_cfg
);
    // the index field is 5 bits, so at most 32 entries are ever addressable
    localparam int MEM_DEPTH = (MOTOR_COUNT < 32) ? MOTOR_COUNT : 32;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [CNT_W:0] FULL_SET = (CNT_W + 1)'(MOTOR_COUNT);

    // ---------------- configuration registers ----------------
    logic [TOL_W-1:0] r_tol;
    logic [MS_W-1:0]  r_timeout;
    logic [MS_W-1:0]  r_settle_dur;
    logic [ITV_W-1:0] r_interval;
    logic [MS_W-1:0]  r_max_dur;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol        <= RST_TOLERANCE;
            r_timeout    <= RST_TIMEOUT;
            r_settle_dur <= RST_SETTLE;
            r_interval   <= RST_INTERVAL;
            r_max_dur    <= RST_MAX_DUR;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                REG_TOLERANCE: r_tol        <= i_cfg.data.value[TOL_W-1:0];
                REG_TIMEOUT:   r_timeout    <= i_cfg.data.value[MS_W-1:0];
                REG_SETTLE:    r_settle_dur <= i_cfg.data.value[MS_W-1:0];
                REG_INTERVAL:  r_interval   <= i_cfg.data.value[ITV_W-1:0];
                REG_MAX_DUR:   r_max_dur    <= i_cfg.data.value[MS_W-1:0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ---------------- handshake and pipeline control ----------------
    logic      r_s1_valid;
    t_in_item  r_s1;
    logic      r_out_valid;
    t_out_item r_out;
    logic      s1_adv;
    logic      in_ready;
    logic      in_acc;

    assign s1_adv   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_s1_valid || s1_adv;
    assign in_acc   = i_in.valid && in_ready;

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in.data;
        end
    end

    // ---------------- target angle memory ----------------
    logic                      ram_we;
    logic [MEM_AW-1:0]         ram_waddr;
    logic [MEM_AW-1:0]         ram_raddr;
    logic [ANGLE_W-1:0]        ram_rdata;
    logic                      r_fwd;
    logic [ANGLE_W-1:0]        r_fwd_data;
    logic signed [ANGLE_W-1:0] tgt;
    logic                      load_ok;

    assign ram_we    = s1_adv && load_ok;
    assign ram_waddr = r_s1.motor_index[MEM_AW-1:0];
    assign ram_raddr = i_in.data.motor_index[MEM_AW-1:0];

    psm_ram #(
        .WIDTH (ANGLE_W),
        .DEPTH (MEM_DEPTH)
    ) u_target_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_s1.angle),
        .i_re    (in_acc),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // a load committing on the edge a request reads the same entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (in_acc) begin
            r_fwd <= ram_we && (ram_waddr == ram_raddr);
        end else if (s1_adv) begin
            r_fwd <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fwd_data <= r_s1.angle;
        end
    end

    assign tgt = r_fwd ? $signed(r_fwd_data) : $signed(ram_rdata);

    // ---------------- monitor state ----------------
    t_phase              r_phase,     n_phase;
    t_err                r_err,       n_err;
    logic [MS_W-1:0]     r_move_time, n_move_time;
    logic [MS_W-1:0]     r_move_dur,  n_move_dur;
    logic [SETTLE_W-1:0] r_settle,    n_settle;
    logic [ITV_W-1:0]    r_tsc,       n_tsc;
    logic                r_checked,   n_checked;
    logic                r_pending,   n_pending;
    logic                r_set_all,   n_set_all;
    logic [CNT_W-1:0]    r_count,     n_count;
    logic                r_within,    n_within;
    logic [SETTLE_W-1:0] r_stable,    n_stable;

    // ---------------- event decode ----------------
    logic                 busy;
    logic                 busy_rej;
    logic                 start_bad;
    logic                 start_ok;
    logic                 is_tick;
    logic                 tick_run;
    logic                 tick_set;
    logic                 reach;
    logic                 tick_check;
    logic                 timeout;
    logic                 request;
    logic                 samp;
    logic                 rfail;
    logic                 samp_ok;
    logic                 in_range;
    logic                 within_tol;
    logic                 set_next;
    logic                 set_good;
    logic                 set_end;
    logic                 success;
    logic [MS_W-1:0]      mt_inc;
    logic [SETTLE_W-1:0]  st_inc;
    logic [SETTLE_W-1:0]  stab_inc;
    logic [ITV_W-1:0]     tsc_inc;
    logic [SETTLE_W-1:0]  eff_st;
    logic [ITV_W-1:0]     eff_tsc;
    logic [CNT_W-1:0]     cnt_next;
    logic signed [ANGLE_W:0] diff;
    logic [ANGLE_W:0]     mag;

    always_comb begin
        busy     = (r_phase == PH_RUNNING) || (r_phase == PH_SETTLING);
        in_range = {2'b00, r_s1.motor_index} < FULL_SET;

        busy_rej  = ((r_s1.command == CMD_LOAD) || (r_s1.command == CMD_START)) && busy;
        load_ok   = (r_s1.command == CMD_LOAD) && !busy && in_range;
        start_bad = (r_s1.command == CMD_START) && !busy
                    && ((r_s1.dur_ms == '0) || (r_s1.dur_ms > r_max_dur));
        start_ok  = (r_s1.command == CMD_START) && !busy && !start_bad;

        // saturating counters
        mt_inc   = (&r_move_time) ? r_move_time : r_move_time + 1'b1;
        st_inc   = (&r_settle)    ? r_settle    : r_settle + 1'b1;
        stab_inc = (&r_stable)    ? r_stable    : r_stable + 1'b1;
        tsc_inc  = (&r_tsc)       ? r_tsc       : r_tsc + 1'b1;

        is_tick  = (r_s1.command == CMD_TICK) && busy;
        tick_run = is_tick && (r_phase == PH_RUNNING);
        tick_set = is_tick && (r_phase == PH_SETTLING);
        reach    = tick_run && !(mt_inc < r_move_dur);

        // entering settling restarts the settle clock; the check clock is still 0
        eff_st     = tick_set ? st_inc  : '0;
        eff_tsc    = tick_set ? tsc_inc : r_tsc;
        tick_check = reach || tick_set;
        timeout    = tick_check && (eff_st > {1'b0, r_timeout});
        request    = tick_check && !timeout && !r_pending
                     && (!r_checked || !(eff_tsc < r_interval));

        samp    = (r_s1.command == CMD_SAMPLE) && (r_phase == PH_SETTLING) && r_pending;
        rfail   = samp && r_s1.read_failed;
        samp_ok = samp && !r_s1.read_failed;

        diff       = $signed({tgt[ANGLE_W-1], tgt})
                     - $signed({r_s1.angle[ANGLE_W-1], r_s1.angle});
        mag        = diff[ANGLE_W] ? $unsigned(-diff) : $unsigned(diff);
        within_tol = mag <= {2'b00, r_tol};

        // an out-of-range motor counts as missing
        set_next = r_set_all && in_range && within_tol;
        cnt_next = (in_range && !(&r_count)) ? r_count + 1'b1 : r_count;
        set_end  = samp_ok && r_s1.last_sample;
        set_good = set_next && ({1'b0, cnt_next} >= FULL_SET);
        success  = set_end && set_good && r_within && (r_stable >= {1'b0, r_settle_dur});
    end

    // ---------------- next phase and stored error ----------------
    always_comb begin
        n_phase = r_phase;
        n_err   = r_err;
        if (start_bad) begin
            n_phase = PH_FAILED;
            n_err   = ERR_DURATION;
        end else if (start_ok) begin
            n_phase = PH_RUNNING;
            n_err   = ERR_NONE;
        end else if (timeout) begin
            n_phase = PH_FAILED;
            n_err   = ERR_TIMEOUT;
        end else if (reach) begin
            n_phase = PH_SETTLING;
        end else if (rfail) begin
            n_phase = PH_FAILED;
            n_err   = ERR_READ;
        end else if (success) begin
            n_phase = PH_SUCCEEDED;
            n_err   = ERR_NONE;
        end
    end

    // ---------------- counters, flags and result ----------------
    t_out_item n_out;

    always_comb begin
        n_move_time = r_move_time;
        n_move_dur  = r_move_dur;
        n_settle    = r_settle;
        n_tsc       = r_tsc;
        n_checked   = r_checked;
        n_pending   = r_pending;
        n_set_all   = r_set_all;
        n_count     = r_count;
        n_within    = r_within;
        n_stable    = r_stable;

        if (start_ok) begin
            n_move_time = '0;
            n_move_dur  = r_s1.dur_ms;
            n_settle    = '0;
            n_tsc       = '0;
            n_checked   = 1'b0;
            n_pending   = 1'b0;
            n_set_all   = 1'b1;
            n_count     = '0;
            n_within    = 1'b0;
            n_stable    = '0;
        end

        if (tick_run) begin
            n_move_time = mt_inc;
        end
        if (tick_check) begin
            n_settle = eff_st;
        end
        if (tick_set) begin
            n_tsc = tsc_inc;
            if (r_within) begin
                n_stable = stab_inc;
            end
        end
        if (timeout || rfail) begin
            n_pending = 1'b0;
        end
        if (request) begin
            n_tsc     = '0;
            n_checked = 1'b1;
            n_pending = 1'b1;
            n_set_all = 1'b1;
            n_count   = '0;
        end

        if (samp_ok) begin
            n_set_all = set_next;
            n_count   = cnt_next;
        end
        if (set_end) begin
            n_pending = 1'b0;
            if (!set_good) begin
                n_within = 1'b0;
            end else if (!r_within) begin
                n_within = 1'b1;
                n_stable = '0;
            end
        end

        n_out.status       = n_phase;
        n_out.error        = busy_rej ? ERR_BUSY : n_err;
        n_out.accepted     = load_ok || start_ok || is_tick || samp;
        n_out.read_request = request;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_err       <= ERR_NONE;
            r_move_time <= '0;
            r_move_dur  <= '0;
            r_settle    <= '0;
            r_tsc       <= '0;
            r_checked   <= 1'b0;
            r_pending   <= 1'b0;
            r_set_all   <= 1'b1;
            r_count     <= '0;
            r_within    <= 1'b0;
            r_stable    <= '0;
        end else if (s1_adv) begin
            r_phase     <= n_phase;
            r_err       <= n_err;
            r_move_time <= n_move_time;
            r_move_dur  <= n_move_dur;
            r_settle    <= n_settle;
            r_tsc       <= n_tsc;
            r_checked   <= n_checked;
            r_pending   <= n_pending;
            r_set_all   <= n_set_all;
            r_count     <= n_count;
            r_within    <= n_within;
            r_stable    <= n_stable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    // a read can only be outstanding while settling
    a_pending_settling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_SETTLING) |-> !r_pending)
        else $error("read pending outside settling");

    // a request result leaves a read outstanding
    a_request_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && request) |=> r_pending)
        else $error("read request without pending read");

    // every evaluated request produces a result in the output register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("result lost from stage 1");

    // forwarding only ever applies to a request held in stage 1
    a_fwd_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forwarded angle without a request in stage 1");

    // a read request is never raised while one is already outstanding
    a_no_double_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_pending) |-> !request)
        else $error("second read request while pending");
`endif
endmodule

/* src/psm_ram.sv */
// psm_ram: generic single-write, single-read RAM with registered read data.
// No package dependency; contents are undefined until written.
module psm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
